// File: hw/rtl/suvs_pkg.sv
package suvs_pkg;

   // item field widths
   localparam int POS_IN_W = 23;
   localparam int FT_W     = 16;
   localparam int OFS_W    = 15;

   // position difference, its magnitude, square and sum of squares
   localparam int DIFF_W = POS_IN_W + 1;
   localparam int ABS_W  = POS_IN_W;
   localparam int SQ_W   = 2 * ABS_W;
   localparam int SUM_W  = SQ_W + 2;

   // rates in units per second
   localparam int RATE_W = 8;
   localparam logic [RATE_W-1:0] SLOW_RATE        = 8'd100;
   localparam logic [RATE_W-1:0] FAST_RATE        = 8'd160;
   localparam logic [RATE_W-1:0] EXTRA_DECAY_RATE = 8'd200;
   localparam logic [RATE_W-1:0] RECOVER_RATE     = 8'd150;

   // distances in whole units
   localparam int TELEPORT_DIST = 48;
   localparam int STEEP_RISE    = 20;
   localparam int BASE_LAG      = 15;
   localparam int EXTRA_CAP     = 5;

endpackage

// File: hw/rtl/suvs_req_if.sv
interface suvs_req_if;
   import suvs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [POS_IN_W-1:0] pos_x;
   logic signed [POS_IN_W-1:0] pos_y;
   logic signed [POS_IN_W-1:0] pos_z;
   logic                       on_ground;
   logic [FT_W-1:0]            frame_time;

   modport source (
      output valid, pos_x, pos_y, pos_z, on_ground, frame_time,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, pos_z, on_ground, frame_time,
      output ready
   );

endinterface

// File: hw/rtl/suvs_rsp_if.sv
interface suvs_rsp_if;
   import suvs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OFS_W-1:0] view_offset;

   modport source (
      output valid, view_offset,
      input  ready
   );

   modport sink (
      input  valid, view_offset,
      output ready
   );

endinterface

// File: hw/rtl/suvs_track.sv
module suvs_track #(
   parameter int POS_BITS  = 24,
   parameter int FRAC_BITS = 8
) (
   input  logic signed [suvs_pkg::POS_IN_W-1:0]                  pos_z,
   input  logic                                                  on_ground,
   input  logic                                                  teleport,
   input  logic [FRAC_BITS+7:0]                                  decay_step,
   input  logic [FRAC_BITS+7:0]                                  fast_step,
   input  logic [FRAC_BITS+7:0]                                  slow_step,
   input  logic [FRAC_BITS+7:0]                                  recover_step,
   input  logic signed [(POS_BITS > suvs_pkg::POS_IN_W ? POS_BITS
                                      : suvs_pkg::POS_IN_W)-1:0] cur_height,
   input  logic [FRAC_BITS+2:0]                                  cur_extra,
   input  logic                                                  cur_fast,
   input  logic signed [suvs_pkg::OFS_W-1:0]                     cur_offset,
   output logic signed [(POS_BITS > suvs_pkg::POS_IN_W ? POS_BITS
                                      : suvs_pkg::POS_IN_W)-1:0] nxt_height,
   output logic [FRAC_BITS+2:0]                                  nxt_extra,
   output logic                                                  nxt_fast,
   output logic signed [suvs_pkg::OFS_W-1:0]                     nxt_offset
);
   import suvs_pkg::*;

   localparam int TH_W = (POS_BITS > POS_IN_W) ? POS_BITS : POS_IN_W;
   localparam int CW   = TH_W + 3;
   localparam int EX_W = FRAC_BITS + 3;

   localparam logic signed [CW-1:0] STEEP_V  = CW'(STEEP_RISE * (1 << FRAC_BITS));
   localparam logic signed [CW-1:0] BASE_V   = CW'(BASE_LAG * (1 << FRAC_BITS));
   localparam logic signed [CW-1:0] EXCAP_V  = CW'(EXTRA_CAP * (1 << FRAC_BITS));
   localparam logic signed [CW-1:0] PMAX_V   = CW'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
   localparam logic signed [CW-1:0] PMIN_V   = CW'(-(64'sd1 <<< (POS_BITS - 1)));
   localparam logic signed [CW-1:0] OMAX_V   = CW'((1 << (OFS_W - 1)) - 1);
   localparam logic signed [CW-1:0] OMIN_V   = CW'(-(1 << (OFS_W - 1)));
   localparam logic signed [CW-1:0] ZERO_V   = '0;

   logic signed [CW-1:0] z, h, ex_old;
   logic signed [CW-1:0] dec_s, fast_s, slow_s, rec_s;
   logic signed [CW-1:0] rise, ex_fresh, ex_capped, ex_a;
   logic signed [CW-1:0] h1, h2, limit, h3, h_sat, ex2, ex3, ofs, rec;
   logic                 steep, rising, fast_a;

   always_comb begin
      z      = CW'(pos_z);
      h      = CW'(cur_height);
      ex_old = CW'(cur_extra);
      dec_s  = CW'(decay_step);
      fast_s = CW'(fast_step);
      slow_s = CW'(slow_step);
      rec_s  = CW'(recover_step);

      rise   = z - h;
      rising = on_ground && (rise > ZERO_V);
      steep  = rise > STEEP_V;

      // extra lag is taken fresh on the first steep rise only
      ex_fresh  = rise - dec_s - BASE_V;
      ex_capped = (ex_fresh > EXCAP_V) ? EXCAP_V : ex_fresh;
      ex_a      = (steep && !cur_fast) ? ex_capped : ex_old;
      fast_a    = steep || cur_fast;

      h1    = h + (fast_a ? fast_s : slow_s);
      h2    = (h1 > z) ? z : h1;
      limit = BASE_V + ex_a;
      h3    = ((z - h2) > limit) ? (z - limit) : h2;

      ex2 = ex_a - dec_s;
      ex3 = (ex2 < ZERO_V) ? ZERO_V : ex2;

      h_sat = (h3 > PMAX_V) ? PMAX_V : ((h3 < PMIN_V) ? PMIN_V : h3);
      ofs   = h3 - z;
      ofs   = (ofs > OMAX_V) ? OMAX_V : ((ofs < OMIN_V) ? OMIN_V : ofs);

      // recovery toward zero: a negative offset rises by the step, never past zero, a positive one snaps to zero
      rec = CW'(cur_offset) + rec_s;
      rec = (rec > ZERO_V) ? ZERO_V : rec;

      if (teleport) begin
         nxt_height = TH_W'(pos_z);
         nxt_extra  = '0;
         nxt_fast   = 1'b0;
         nxt_offset = '0;
      end else if (rising) begin
         nxt_height = h_sat[TH_W-1:0];
         nxt_extra  = ex3[EX_W-1:0];
         nxt_fast   = fast_a;
         nxt_offset = ofs[OFS_W-1:0];
      end else begin
         nxt_height = TH_W'(pos_z);
         nxt_extra  = '0;
         nxt_fast   = 1'b0;
         nxt_offset = rec[OFS_W-1:0];
      end
   end

endmodule

// File: hw/rtl/step_up_view_smoother.sv
// step_up_view_smoother
//
// smooths the vertical view offset as a player walks up stairs. one req item
// per frame carries the position (x, y, height, signed, FRAC_BITS fraction
// bits), the on-ground flag and the frame time in 1/65536 s; one rsp item per
// req item carries the saturated view offset in the same position units.
//
// channels are valid/ready; an item moves on a clock edge with both high.
// an accepted item is loaded into the input register (position deltas and rate
// steps are formed on the way in), then moves on into the result register.
// throughput is one item per clock while rsp is not held off, set by the
// single state update in the result stage.
//
// the input register keeps accepting while a finished result waits, so with
// rsp held off the block fills both registers and then drops req ready;
// nothing is lost or repeated. synchronous reset clears the filter state and
// the last position to zero and empties both registers.
module step_up_view_smoother #(
   parameter int POS_BITS  = 24,
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   suvs_req_if.sink    req_if,
   suvs_rsp_if.source  rsp_if
);
   import suvs_pkg::*;

   localparam int TH_W   = (POS_BITS > POS_IN_W) ? POS_BITS : POS_IN_W;
   localparam int EX_W   = FRAC_BITS + 3;
   localparam int SH     = FT_W - FRAC_BITS;
   localparam int PROD_W = FT_W + RATE_W;
   localparam int STEP_W = PROD_W - SH;
   localparam logic [SUM_W-1:0] THR_SQ =
      SUM_W'(64'(TELEPORT_DIST * (1 << FRAC_BITS)) *
             64'(TELEPORT_DIST * (1 << FRAC_BITS)));

   // handshake
   logic s1_vld_ff, s1_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic out_free, s1_fire, accept;

   // previous position, updated as each item is accepted
   logic signed [POS_IN_W-1:0] last_x_ff, last_y_ff, last_z_ff;

   // input register
   logic [ABS_W-1:0]           dx_ff, dy_ff, dz_ff;
   logic signed [POS_IN_W-1:0] z_ff;
   logic                       gnd_ff;
   logic [STEP_W-1:0]          dec_ff, fast_step_ff, slow_step_ff, rec_ff;

   // filter state; the offset register is also the rsp payload
   logic signed [TH_W-1:0]  height_ff, height_in;
   logic [EX_W-1:0]         extra_ff, extra_in;
   logic                    fast_ff, fast_in;
   logic signed [OFS_W-1:0] offset_ff, offset_in;

   logic signed [DIFF_W-1:0] diff_x, diff_y, diff_z;
   logic [PROD_W-1:0]        prod_dec, prod_fast, prod_slow, prod_rec;
   logic [SQ_W-1:0]          sq_x, sq_y, sq_z;
   logic [SUM_W-1:0]         dist_sq;
   logic                     teleport;

   function automatic logic [ABS_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
      logic signed [DIFF_W-1:0] m;
      m = d[DIFF_W-1] ? -d : d;
      return m[ABS_W-1:0];
   endfunction

   // a new item may enter whenever the input register is empty or empties this cycle
   assign out_free     = !rsp_vld_ff || rsp_if.ready;
   assign s1_fire      = s1_vld_ff && out_free;
   assign req_if.ready = !s1_vld_ff || out_free;
   assign accept       = req_if.valid && req_if.ready;

   assign s1_vld_in  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_vld_ff);
   assign rsp_vld_in = s1_fire ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_vld_ff);

   assign rsp_if.valid       = rsp_vld_ff;
   assign rsp_if.view_offset = offset_ff;

   // entry side: deltas against the last position, rate times frame time
   always_comb begin
      diff_x    = DIFF_W'(req_if.pos_x) - DIFF_W'(last_x_ff);
      diff_y    = DIFF_W'(req_if.pos_y) - DIFF_W'(last_y_ff);
      diff_z    = DIFF_W'(req_if.pos_z) - DIFF_W'(last_z_ff);
      prod_dec  = PROD_W'(req_if.frame_time) * PROD_W'(EXTRA_DECAY_RATE);
      prod_fast = PROD_W'(req_if.frame_time) * PROD_W'(FAST_RATE);
      prod_slow = PROD_W'(req_if.frame_time) * PROD_W'(SLOW_RATE);
      prod_rec  = PROD_W'(req_if.frame_time) * PROD_W'(RECOVER_RATE);
   end

   // teleport test: squared distance against 48 units squared
   always_comb begin
      sq_x     = SQ_W'(dx_ff) * SQ_W'(dx_ff);
      sq_y     = SQ_W'(dy_ff) * SQ_W'(dy_ff);
      sq_z     = SQ_W'(dz_ff) * SQ_W'(dz_ff);
      dist_sq  = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
      teleport = dist_sq > THR_SQ;
   end

   suvs_track #(
      .POS_BITS  (POS_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_track (
      .pos_z        (z_ff),
      .on_ground    (gnd_ff),
      .teleport     (teleport),
      .decay_step   (dec_ff),
      .fast_step    (fast_step_ff),
      .slow_step    (slow_step_ff),
      .recover_step (rec_ff),
      .cur_height   (height_ff),
      .cur_extra    (extra_ff),
      .cur_fast     (fast_ff),
      .cur_offset   (offset_ff),
      .nxt_height   (height_in),
      .nxt_extra    (extra_in),
      .nxt_fast     (fast_in),
      .nxt_offset   (offset_in)
   );

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         last_z_ff  <= '0;
         height_ff  <= '0;
         extra_ff   <= '0;
         fast_ff    <= 1'b0;
         offset_ff  <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (accept) begin
            last_x_ff <= req_if.pos_x;
            last_y_ff <= req_if.pos_y;
            last_z_ff <= req_if.pos_z;
         end
         if (s1_fire) begin
            height_ff <= height_in;
            extra_ff  <= extra_in;
            fast_ff   <= fast_in;
            offset_ff <= offset_in;
         end
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff        <= abs_diff(diff_x);
         dy_ff        <= abs_diff(diff_y);
         dz_ff        <= abs_diff(diff_z);
         z_ff         <= req_if.pos_z;
         gnd_ff       <= req_if.on_ground;
         dec_ff       <= prod_dec[PROD_W-1:SH];
         fast_step_ff <= prod_fast[PROD_W-1:SH];
         slow_step_ff <= prod_slow[PROD_W-1:SH];
         rec_ff       <= prod_rec[PROD_W-1:SH];
      end
   end

   // a waiting item in the input register stays until it moves on
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !out_free) |=> s1_vld_ff)
      else $error("input register lost an item");

   // every result comes from the input register
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s1_vld_ff))
      else $error("result without an item");

   // the extra lag never exceeds its cap
   a_extra_cap: assert property (@(posedge clock) disable iff (reset)
      extra_ff <= EX_W'(EXTRA_CAP * (1 << FRAC_BITS)))
      else $error("extra lag above cap");

   // fast rate only turns on from a grounded item
   a_fast_src: assert property (@(posedge clock) disable iff (reset)
      $rose(fast_ff) |-> $past(s1_fire && gnd_ff))
      else $error("fast rate set off ground");

   // state changes only as an item completes
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> ($stable(offset_ff) && $stable(height_ff)))
      else $error("filter state changed without an item");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import suvs_pkg::*;

   // block parameters, kept at their defaults
   localparam int POS_BITS = 24;
   localparam int FRAC     = 8;

   // cycles with no handshake on either side before the run is declared hung
   localparam int QUIET_LIMIT = 2000;
   // cycles to let pass after the last offset
   localparam int DRAIN_CYCLES = 8;
   // length of the one long receiver hold-off
   localparam int HOLD_CYCLES = 300;

   localparam longint ONE = longint'(1) << FRAC;

   // one frame as it travels on the req channel
   typedef struct packed {
      logic signed [POS_IN_W-1:0] pos_x;
      logic signed [POS_IN_W-1:0] pos_y;
      logic signed [POS_IN_W-1:0] pos_z;
      logic                       on_ground;
      logic [FT_W-1:0]            frame_time;
   } frame_type;

   // directed row: typed marks an offset read off by hand, else the predictor decides
   typedef struct packed {
      frame_type               f;
      logic                    typed;
      logic signed [OFS_W-1:0] ofs;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   suvs_req_if req_bus ();
   suvs_rsp_if rsp_bus ();

   step_up_view_smoother #(
      .POS_BITS  (POS_BITS),
      .FRAC_BITS (FRAC)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // predictor state, mirrors the filter inside the block
   // ---------------------------------------------------------------
   longint prev_pos [3];
   longint track_h;
   longint extra_h;
   longint view_ofs;
   bit     fast_climb;

   // offsets still owed by the block, oldest first
   logic signed [OFS_W-1:0] pending_offsets [$];

   // run bookkeeping
   int n_errors;
   int frames_sent;
   int offsets_checked;
   int n_teleport;
   int n_climb;
   int n_recover;
   int n_clamped;

   // idle percentages for each side, changed between phases
   int req_idle_pct;
   int rsp_idle_pct;

   // long receiver hold-off, requested by the main sequence, counted by the receiver
   bit hold_request;
   bit hold_done;
   int hold_left;

   // random walker position
   longint walk_x;
   longint walk_y;
   longint walk_z;

   row_type step_rows [$];
   logic signed [OFS_W-1:0] want_offset;
   int quiet_cycles;

   function automatic longint clamp_bits(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // distance covered in one frame at a rate in units per second
   function automatic longint rate_dist(logic [FT_W-1:0] ft, logic [RATE_W-1:0] rate);
      return (longint'(ft) * longint'(rate)) >>> (16 - FRAC);
   endfunction

   function automatic void reset_filter();
      for (int i = 0; i < 3; i++) prev_pos[i] = 0;
      track_h    = 0;
      extra_h    = 0;
      view_ofs   = 0;
      fast_climb = 1'b0;
   endfunction

   // advance the filter by one frame and give the view offset it produces
   function automatic logic signed [OFS_W-1:0] smooth_frame(frame_type f);
      longint p [3];
      longint d;
      longint dist2;
      longint thr;
      longint z;
      longint h;
      longint ex;
      longint lim;
      longint c;
      p[0] = longint'($signed(f.pos_x));
      p[1] = longint'($signed(f.pos_y));
      p[2] = longint'($signed(f.pos_z));
      dist2 = 0;
      for (int i = 0; i < 3; i++) begin
         d = p[i] - prev_pos[i];
         dist2 += d * d;
         prev_pos[i] = p[i];
      end
      thr = TELEPORT_DIST * ONE;

      if (dist2 > thr * thr) begin
         // jumped too far, start over at the new height
         track_h    = p[2];
         extra_h    = 0;
         fast_climb = 1'b0;
         view_ofs   = 0;
         n_teleport++;
      end else if (f.on_ground && p[2] - track_h > 0) begin
         // climbing on ground, tracked height chases the true height
         z  = p[2];
         h  = track_h;
         ex = extra_h;
         if (z - h > STEEP_RISE * ONE) begin
            // first steep frame sets the extra lag, may come out negative
            if (!fast_climb) begin
               ex = z - h - rate_dist(f.frame_time, EXTRA_DECAY_RATE) - BASE_LAG * ONE;
               if (ex > EXTRA_CAP * ONE) ex = EXTRA_CAP * ONE;
            end
            fast_climb = 1'b1;
         end
         h += rate_dist(f.frame_time, fast_climb ? FAST_RATE : SLOW_RATE);
         if (h > z) h = z;
         lim = BASE_LAG * ONE + ex;
         if (z - h > lim) h = z - lim;
         ex -= rate_dist(f.frame_time, EXTRA_DECAY_RATE);
         if (ex < 0) ex = 0;
         track_h  = clamp_bits(h, POS_BITS);
         extra_h  = clamp_bits(ex, POS_BITS);
         view_ofs = clamp_bits(h - z, OFS_W);
         if (view_ofs != h - z) n_clamped++;
         n_climb++;
      end else begin
         // airborne or level or dropping, offset drifts back to zero
         c = view_ofs + rate_dist(f.frame_time, RECOVER_RATE);
         track_h = p[2];
         if (c > 0) c = 0;
         view_ofs   = clamp_bits(c, OFS_W);
         fast_climb = 1'b0;
         extra_h    = 0;
         n_recover++;
      end
      return view_ofs[OFS_W-1:0];
   endfunction

   function automatic row_type mk_row(int x, int y, int z, bit g, int ft, bit typed, int ofs);
      row_type r;
      r.f.pos_x      = POS_IN_W'(x);
      r.f.pos_y      = POS_IN_W'(y);
      r.f.pos_z      = POS_IN_W'(z);
      r.f.on_ground  = g;
      r.f.frame_time = FT_W'(ft);
      r.typed        = typed;
      r.ofs          = OFS_W'(ofs);
      return r;
   endfunction

   function automatic longint any_pos();
      logic signed [POS_IN_W-1:0] r;
      r = POS_IN_W'($urandom);
      return longint'(r);
   endfunction

   // ---------------------------------------------------------------
   // sender: offer one frame, wait for it to be taken, then predict
   // ---------------------------------------------------------------
   task automatic offer_frame(frame_type f, logic typed, logic signed [OFS_W-1:0] typed_ofs);
      logic signed [OFS_W-1:0] predicted;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.pos_x      <= f.pos_x;
      req_bus.pos_y      <= f.pos_y;
      req_bus.pos_z      <= f.pos_z;
      req_bus.on_ground  <= f.on_ground;
      req_bus.frame_time <= f.frame_time;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // item taken at this edge
      predicted = smooth_frame(f);
      pending_offsets.push_back(typed ? typed_ofs : predicted);
      frames_sent++;
   endtask

   // ---------------------------------------------------------------
   // random frames: mostly a player walking, climbing, jumping and
   // falling, with teleports, near-threshold moves and raw noise mixed in
   // ---------------------------------------------------------------
   task automatic run_random(int count);
      frame_type f;
      int     kind;
      int     sub;
      longint dx;
      longint dy;
      longint dz;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 99);
         f.on_ground = ($urandom_range(0, 99) < 80);
         sub = $urandom_range(0, 99);
         if (sub < 85) f.frame_time = FT_W'($urandom_range(100, 4400));
         else if (sub < 95) f.frame_time = FT_W'($urandom_range(4401, 65535));
         else f.frame_time = (sub < 97) ? '0 : '1;

         if (kind < 4) begin
            // teleport somewhere in the whole space
            walk_x = any_pos();
            walk_y = any_pos();
            walk_z = any_pos();
         end else if (kind < 8) begin
            // noise on x, y, ground flag and frame time, and on z half the time
            walk_x = any_pos();
            walk_y = any_pos();
            walk_z = ($urandom_range(0, 1) != 0) ? any_pos() : walk_z;
            f.on_ground  = ($urandom_range(0, 1) != 0);
            f.frame_time = FT_W'($urandom);
         end else if (kind < 12) begin
            // sideways move right at the teleport distance or just past it
            dx = TELEPORT_DIST * ONE + longint'($urandom_range(0, 1));
            walk_x = clamp_bits(($urandom_range(0, 1) != 0) ? walk_x + dx : walk_x - dx,
                                POS_IN_W);
         end else begin
            dx  = longint'($urandom_range(0, 4000)) - 2000;
            dy  = longint'($urandom_range(0, 4000)) - 2000;
            sub = $urandom_range(0, 99);
            if (sub < 30) dz = longint'($urandom_range(1, 40 * 256)); // step up, steep at times
            else if (sub < 55) dz = longint'($urandom_range(0, 512)) - 256;
            else if (sub < 75) dz = 0;
            else dz = -longint'($urandom_range(1, 30 * 256));        // step down
            walk_x = clamp_bits(walk_x + dx, POS_IN_W);
            walk_y = clamp_bits(walk_y + dy, POS_IN_W);
            walk_z = clamp_bits(walk_z + dz, POS_IN_W);
         end
         f.pos_x = walk_x[POS_IN_W-1:0];
         f.pos_y = walk_y[POS_IN_W-1:0];
         f.pos_z = walk_z[POS_IN_W-1:0];
         offer_frame(f, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------
   // receiver: check each offset taken, then pick ready for the next cycle
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_offsets.size() == 0) begin
            $display("%0t: view offset %0d arrived with none expected",
                     $time, rsp_bus.view_offset);
            n_errors++;
         end else begin
            want_offset = pending_offsets.pop_front();
            if (rsp_bus.view_offset !== want_offset) begin
               $display("%0t: view_offset mismatch, expected %0d actual %0d",
                        $time, want_offset, rsp_bus.view_offset);
               n_errors++;
            end
            offsets_checked++;
         end
      end
      // the one long hold-off, so the block fills and pushes back on req
      if (hold_request && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // watchdog: any handshake restarts the count
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d offsets outstanding",
                  $time, QUIET_LIMIT, pending_offsets.size());
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.pos_x      <= '0;
      req_bus.pos_y      <= '0;
      req_bus.pos_z      <= '0;
      req_bus.on_ground  <= 1'b0;
      req_bus.frame_time <= '0;
      n_errors        = 0;
      frames_sent     = 0;
      offsets_checked = 0;
      n_teleport      = 0;
      n_climb         = 0;
      n_recover       = 0;
      n_clamped       = 0;
      hold_request    = 1'b0;
      walk_x          = 0;
      walk_y          = 0;
      walk_z          = 0;
      req_idle_pct    = 13;
      rsp_idle_pct    = 60;
      reset_filter();

      // directed frames                  x         y         z   gnd    ft  typed  ofs
      // first frame is measured from the zeroed last position
      step_rows.push_back(mk_row(       0,        0,        0, 1,  1092, 1,     0));
      // exactly 48 units sideways stays put, one step more is a teleport
      step_rows.push_back(mk_row(   12288,        0,        0, 1,  1092, 1,     0));
      step_rows.push_back(mk_row(   24577,        0,        0, 1,  1092, 1,     0));
      // corners of the position range, frame time extremes
      step_rows.push_back(mk_row(-4194304, -4194304, -4194304, 0,     0, 1,     0));
      step_rows.push_back(mk_row( 4194303,  4194303,  4194303, 1, 65535, 1,     0));
      step_rows.push_back(mk_row(       0,        0,        0, 1,  1092, 1,     0));
      // 10 unit step with no time passing leaves the whole step as offset
      step_rows.push_back(mk_row(       0,        0,     2560, 1,     0, 1, -2560));
      step_rows.push_back(mk_row(       0,        0,     2560, 1,  1092, 0,     0));
      // steep rise switches to the fast rate
      step_rows.push_back(mk_row(     256,     -256,     8960, 1,   655, 0,     0));
      step_rows.push_back(mk_row(     256,     -256,     8960, 1,  1092, 0,     0));
      step_rows.push_back(mk_row(     512,     -512,     8960, 1,  1092, 0,     0));
      // airborne, then landing lower
      step_rows.push_back(mk_row(     512,     -512,     8960, 0,  1092, 0,     0));
      step_rows.push_back(mk_row(     512,     -512,     5000, 1,  1092, 0,     0));
      // steep rise over a long frame: extra lag goes far negative, offset clamps high
      step_rows.push_back(mk_row(     512,     -512,    15240, 1, 65535, 1, 16383));
      // positive offset snaps back to zero on recovery
      step_rows.push_back(mk_row(     512,     -512,    15240, 1,  1092, 1,     0));
      step_rows.push_back(mk_row(       0,        0,    15240, 1,  1092, 0,     0));
      // steep rise just past 20 units, extra lag slightly negative
      step_rows.push_back(mk_row(       0,        0,    20616, 1,  3000, 0,     0));
      step_rows.push_back(mk_row(       0,        0,    20616, 1,  3000, 0,     0));
      step_rows.push_back(mk_row(       0,        0,    30000, 1,     0, 0,     0));
      step_rows.push_back(mk_row(       0,        0,    30000, 0,     0, 0,     0));
      step_rows.push_back(mk_row(      -1,       -1,    30000, 1, 65535, 0,     0));
      // climbing at the bottom of the height range
      step_rows.push_back(mk_row( 4194303,        0,        0, 1,  1092, 1,     0));
      step_rows.push_back(mk_row( 4194303,        0, -4194304, 1,  1092, 1,     0));
      step_rows.push_back(mk_row( 4194303,        0, -4188304, 1,  1092, 0,     0));
      step_rows.push_back(mk_row( 4194303,        0, -4188304, 1,  1092, 0,     0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 1: sender idles a little, receiver a lot
      foreach (step_rows[i]) offer_frame(step_rows[i].f, step_rows[i].typed, step_rows[i].ofs);
      walk_x = 4194303;
      walk_y = 0;
      walk_z = -4188304;
      run_random(170);

      // phase 2: the other way round
      req_idle_pct = 60;
      rsp_idle_pct = 13;
      run_random(165);

      // phase 3: no idling, with one long hold-off on the result side
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(60);
      hold_request = 1'b1;
      run_random(105);
      req_bus.valid <= 1'b0;

      // drain; the watchdog covers a block that never answers
      while (pending_offsets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d frames: %0d teleports, %0d on-ground climbs, %0d recovery frames",
               frames_sent, n_teleport, n_climb, n_recover);
      $display("%0d offsets checked, %0d climbs clamped at the offset limit, %0d mismatches",
               offsets_checked, n_clamped, n_errors);
      if (n_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
